// ----- rtl/radc_pkg.sv -----
// radc_pkg: shared types, constants and digit/glyph helpers of the radix converter.
// No dependencies; used by radc_div and radix_converter.
`default_nettype none

package radc_pkg;

	localparam int CHAR_W      = 8;
	localparam int BASE_W      = 6;
	localparam int DIGIT_W     = 6;
	localparam int STACK_DEPTH = 64;
	localparam int PTR_W       = 6;
	localparam int CNT_W       = 7;

	localparam logic [BASE_W-1:0] BASE_MIN          = 6'd2;
	localparam logic [BASE_W-1:0] BASE_MAX          = 6'd36;
	localparam logic [BASE_W-1:0] SOURCE_BASE_RESET = 6'd10;
	localparam logic [BASE_W-1:0] TARGET_BASE_RESET = 6'd2;

	typedef enum logic [0:0] {
		REG_SOURCE_BASE = 1'b0,
		REG_TARGET_BASE = 1'b1
	} reg_index_t;

	// radix register saturated into 2..36
	function automatic logic [BASE_W-1:0] clamp_base(input logic [BASE_W-1:0] b);
		logic [BASE_W-1:0] r;
		if (b < BASE_MIN) begin
			r = BASE_MIN;
		end else if (b > BASE_MAX) begin
			r = BASE_MAX;
		end else begin
			r = b;
		end
		return r;
	endfunction

	// '0'-'9' -> 0-9, 'A'-'Z' -> 10-35, anything else -> 0
	function automatic logic [DIGIT_W-1:0] char_value(input logic [CHAR_W-1:0] c);
		logic [CHAR_W-1:0] t;
		t = '0;
		if (c inside {[8'h30:8'h39]}) begin
			t = c - 8'h30;
		end else if (c inside {[8'h41:8'h5A]}) begin
			t = c - 8'h37;
		end
		return t[DIGIT_W-1:0];
	endfunction

	// digit value -> ASCII glyph (values above 35 never occur)
	function automatic logic [CHAR_W-1:0] glyph(input logic [DIGIT_W-1:0] d);
		logic [CHAR_W-1:0] r;
		if (d < 6'd10) begin
			r = 8'h30 + {2'b00, d};
		end else begin
			r = 8'h37 + {2'b00, d};
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/radc_div.sv -----
// radc_div: restoring divider, one quotient bit per cycle, by a radix of 2..36.
// Depends on radc_pkg.
`default_nettype none

module radc_div #(
	parameter int VALUE_BITS = 64
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            start,
	input  wire logic [VALUE_BITS-1:0]           dividend,
	input  wire logic [radc_pkg::BASE_W-1:0]     divisor,
	output logic                                 done,
	output logic [VALUE_BITS-1:0]                quotient,
	output logic [radc_pkg::DIGIT_W-1:0]         remainder
);

	localparam int CW = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;
	localparam logic [CW-1:0] LAST_STEP = CW'(VALUE_BITS - 1);

	logic                             busy_q;
	logic                             done_q;
	logic [CW-1:0]                    step_q;
	logic [VALUE_BITS-1:0]            q_q;
	logic [radc_pkg::DIGIT_W-1:0]     r_q;
	logic [radc_pkg::BASE_W-1:0]      div_q;

	logic [radc_pkg::DIGIT_W:0]       trial;
	logic [radc_pkg::DIGIT_W:0]       diff;
	logic                             fits;

	// shift in the next dividend bit, subtract the divisor if it fits
	assign trial = {r_q, q_q[VALUE_BITS-1]};
	assign fits  = trial >= {1'b0, div_q};
	assign diff  = trial - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == LAST_STEP) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q   <= dividend;
			r_q   <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			q_q <= {q_q[VALUE_BITS-2:0], fits};
			r_q <= fits ? diff[radc_pkg::DIGIT_W-1:0] : trial[radc_pkg::DIGIT_W-1:0];
		end
	end

	assign done      = done_q;
	assign quotient  = q_q;
	assign remainder = r_q;

endmodule

`default_nettype wire

// ----- rtl/radix_converter.sv -----
// radix_converter: Horner accumulation in one radix, repeated division into another.
// Depends on radc_pkg and radc_div.
// A character not marked last is folded into the accumulator while idle. A last character starts
// conversion: each target digit is produced by the bit-serial divider
// (at most STACK_DEPTH = 64 digits), then each digit is read from the digit stack and shown,
// waiting while the output stalls. No item is taken until the final digit leaves.
// Reset: asynchronous, active low; clears accumulator, digit count and state, radices to 10/2.
`default_nettype none

module radix_converter #(
	parameter int VALUE_BITS = 64
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	// input items
	input  wire logic                            in_valid,
	output logic                                 in_stall,
	input  wire logic [radc_pkg::CHAR_W-1:0]     char_in,
	input  wire logic                            last_char,
	// result items
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output logic [radc_pkg::CHAR_W-1:0]          digit_char,
	output logic                                 last_digit,
	// configuration writes
	input  wire logic                            cfg_we,
	input  wire logic [0:0]                      cfg_index,
	input  wire logic [radc_pkg::BASE_W-1:0]     cfg_data
);

	// sequencer states, one-hot
	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,  // taking characters
		ST_DIV  = 4'b0010,  // divider producing one target digit
		ST_READ = 4'b0100,  // fetch next digit from the stack
		ST_EMIT = 4'b1000   // digit on the output, waiting for take-up
	} state_t;

	state_t                          state_q;
	logic [radc_pkg::BASE_W-1:0]     src_base_q;
	logic [radc_pkg::BASE_W-1:0]     tgt_base_q;
	logic [VALUE_BITS-1:0]           acc_q;
	logic [radc_pkg::CNT_W-1:0]      cnt_q;
	logic [radc_pkg::DIGIT_W-1:0]    rd_q;

	// digit stack, least significant digit at entry 0
	logic [radc_pkg::DIGIT_W-1:0]    stack_mem [radc_pkg::STACK_DEPTH];

	logic                            in_acc;
	logic                            out_acc;
	logic [radc_pkg::BASE_W-1:0]     src_base;
	logic [radc_pkg::BASE_W-1:0]     tgt_base;
	logic [VALUE_BITS-1:0]           horner;
	logic [radc_pkg::CNT_W-1:0]      cnt_inc;
	logic [radc_pkg::CNT_W-1:0]      cnt_dec;
	logic                            more_digits;

	logic                            div_start;
	logic [VALUE_BITS-1:0]           div_dividend;
	logic                            div_done;
	logic [VALUE_BITS-1:0]           div_quot;
	logic [radc_pkg::DIGIT_W-1:0]    div_rem;

	assign in_stall = (state_q != ST_IDLE);
	assign in_acc   = in_valid && (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_EMIT);
	assign out_acc  = out_valid && !out_stall;

	assign src_base = radc_pkg::clamp_base(src_base_q);
	assign tgt_base = radc_pkg::clamp_base(tgt_base_q);

	// acc*base + digit, wrapping at VALUE_BITS
	assign horner = acc_q * {{(VALUE_BITS-radc_pkg::BASE_W){1'b0}}, src_base}
		+ {{(VALUE_BITS-radc_pkg::DIGIT_W){1'b0}}, radc_pkg::char_value(char_in)};

	assign cnt_inc = cnt_q + 1'b1;
	assign cnt_dec = cnt_q - 1'b1;

	// keep dividing while the quotient is non-zero and the stack has room
	assign more_digits = (div_quot != '0)
		&& (cnt_inc != radc_pkg::CNT_W'(radc_pkg::STACK_DEPTH));

	assign div_start    = (in_acc && last_char)
		|| ((state_q == ST_DIV) && div_done && more_digits);
	assign div_dividend = in_acc ? horner : div_quot;

	radc_div #(
		.VALUE_BITS (VALUE_BITS)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_dividend),
		.divisor   (tgt_base),
		.done      (div_done),
		.quotient  (div_quot),
		.remainder (div_rem)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_base_q <= radc_pkg::SOURCE_BASE_RESET;
			tgt_base_q <= radc_pkg::TARGET_BASE_RESET;
		end else if (cfg_we) begin
			if (cfg_index == radc_pkg::REG_SOURCE_BASE) begin
				src_base_q <= cfg_data;
			end else begin
				tgt_base_q <= cfg_data;
			end
		end
	end

	// sequencer, accumulator and digit count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			acc_q   <= '0;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (last_char) begin
							// value is handed to the divider; start afresh
							acc_q   <= '0;
							cnt_q   <= '0;
							state_q <= ST_DIV;
						end else begin
							acc_q <= horner;
						end
					end
				end
				ST_DIV: begin
					if (div_done) begin
						cnt_q <= cnt_inc;
						if (!more_digits) begin
							state_q <= ST_READ;
						end
					end
				end
				ST_READ: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_acc) begin
						cnt_q <= cnt_dec;
						state_q <= (cnt_q == radc_pkg::CNT_W'(1)) ? ST_IDLE : ST_READ;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// digit stack: push remainders, pop most significant first
	always_ff @(posedge clk) begin
		if ((state_q == ST_DIV) && div_done) begin
			stack_mem[cnt_q[radc_pkg::PTR_W-1:0]] <= div_rem;
		end
		if (state_q == ST_READ) begin
			rd_q <= stack_mem[cnt_dec[radc_pkg::PTR_W-1:0]];
		end
	end

	assign digit_char = radc_pkg::glyph(rd_q);
	assign last_digit = (cnt_q == radc_pkg::CNT_W'(1));

endmodule

`default_nettype wire
